// ===== design/rppl_pkg.sv =====
// ----------------------------------------------------------------------------
// rppl_pkg
// Shared types and constants for the ping-pong radio link tester.
// ----------------------------------------------------------------------------
`default_nettype none

package rppl_pkg;

  // Frame bytes
  localparam logic [7:0] FRAME_HEAD   = 8'hA5;
  localparam logic [7:0] TYPE_REQUEST = 8'h01;
  localparam logic [7:0] TYPE_REPLY   = 8'h02;

  // Register reset values
  localparam logic       ROLE_MASTER_RST = 1'b1;
  localparam logic [7:0] COLOR_FIRST_RST = 8'd1;
  localparam logic [7:0] COLOR_LAST_RST  = 8'd3;
  localparam logic [7:0] LED_TICKS_RST   = 8'd10;
  localparam logic [7:0] REPLY_TICKS_RST = 8'd20;
  localparam logic [7:0] NEXT_TICKS_RST  = 8'd30;

  // Register map (index = byte address / 4)
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ROLE_MASTER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_FIRST = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COLOR_LAST  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LED_TICKS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPLY_TICKS = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_NEXT_TICKS  = 3'd5;

  // Master phase codes as shown on phase_now
  localparam logic [1:0] PHASE_CODE_SEND  = 2'd0;
  localparam logic [1:0] PHASE_CODE_WAIT  = 2'd1;
  localparam logic [1:0] PHASE_CODE_PAUSE = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  typedef struct packed {
    logic       command;
    logic       frame_arrived;
    logic [7:0] rx_head;
    logic [7:0] rx_type;
    logic [7:0] rx_sequence;
    logic [7:0] rx_color;
    logic [7:0] rx_check;
  } in_item_t;

  typedef struct packed {
    logic       send_frame;
    logic [7:0] tx_head;
    logic [7:0] tx_type;
    logic [7:0] tx_sequence;
    logic [7:0] tx_color;
    logic [7:0] tx_check;
    logic       led_lit;
    logic [7:0] led_shade;
    logic       keep_awake;
    logic [1:0] phase_now;
  } out_item_t;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic       role_master;
    logic [7:0] color_first;
    logic [7:0] color_last;
    logic [7:0] led_ticks;
    logic [7:0] reply_ticks;
    logic [7:0] next_ticks;
  } cfg_t;

  // Item after classification by the front end
  typedef struct packed {
    logic       poll;
    logic       arrived;
    logic       req_ok;
    logic       rep_ok;
    logic [7:0] seq_num;
    logic [7:0] color;
  } cls_item_t;

  typedef enum logic [2:0] {
    PH_SEND  = 3'b001,
    PH_WAIT  = 3'b010,
    PH_PAUSE = 3'b100
  } phase_e;

endpackage

`default_nettype wire

// ===== design/radio_ping_pong_link_tester.sv =====
// ----------------------------------------------------------------------------
// radio_ping_pong_link_tester
// Ping-pong radio link tester: master requests and checks replies, slave
// answers valid requests; every send lights the LED for a timed period.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload      handshake
//   in        input       in_item_t    in_valid_i / in_stall_o
//   out       output      out_item_t   out_valid_o / out_stall_i
//   config    input       APB          psel, penable, pwrite, paddr, pwdata
//
// One result per item. An accepted item is classified in the same cycle and
// lands in a two-entry queue; the back end executes one item per cycle from
// that queue into the result register while out_stall_i is low; an item's
// result is valid once it has passed the queue entry and the result register.
// The sustained rate is one item per cycle while out_stall_i is low.
// The back end stalls only on out_stall_i; the front stalls only when the
// queue is full, and after an output stall clears the input stays held until
// the full queue has freed an entry. Reset clears the link state and
// registers at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module radio_ping_pong_link_tester import rppl_pkg::*; (
  input  var logic                clk_i,
  input  var logic                rst_ni,
  // Item input
  input  var logic                in_valid_i,
  output logic                    in_stall_o,
  input  var in_item_t            in_item_i,
  // Result output
  output logic                    out_valid_o,
  input  var logic                out_stall_i,
  output out_item_t               out_item_o,
  // Configuration port
  input  var logic                psel,
  input  var logic                penable,
  input  var logic                pwrite,
  input  var logic [PADDR_W-1:0]  paddr,
  input  var logic [31:0]         pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  cfg_t                 cfg_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  cls_item_t            cls_item;
  cls_item_t            q_item;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;

  // ---- configuration registers --------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.role_master <= ROLE_MASTER_RST;
      cfg_q.color_first <= COLOR_FIRST_RST;
      cfg_q.color_last  <= COLOR_LAST_RST;
      cfg_q.led_ticks   <= LED_TICKS_RST;
      cfg_q.reply_ticks <= REPLY_TICKS_RST;
      cfg_q.next_ticks  <= NEXT_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROLE_MASTER: cfg_q.role_master <= pwdata[0];
        REG_COLOR_FIRST: cfg_q.color_first <= pwdata[7:0];
        REG_COLOR_LAST:  cfg_q.color_last  <= pwdata[7:0];
        REG_LED_TICKS:   cfg_q.led_ticks   <= pwdata[7:0];
        REG_REPLY_TICKS: cfg_q.reply_ticks <= pwdata[7:0];
        REG_NEXT_TICKS:  cfg_q.next_ticks  <= pwdata[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Read back the register selected by paddr
  always_comb begin
    unique case (reg_idx)
      REG_ROLE_MASTER: prdata = {31'd0, cfg_q.role_master};
      REG_COLOR_FIRST: prdata = {24'd0, cfg_q.color_first};
      REG_COLOR_LAST:  prdata = {24'd0, cfg_q.color_last};
      REG_LED_TICKS:   prdata = {24'd0, cfg_q.led_ticks};
      REG_REPLY_TICKS: prdata = {24'd0, cfg_q.reply_ticks};
      REG_NEXT_TICKS:  prdata = {24'd0, cfg_q.next_ticks};
      default:         prdata = 32'd0;
    endcase
  end

  // ---- front end: classify incoming item ----------------------------------
  rppl_front u_front (
    .cfg_i  (cfg_q),
    .item_i (in_item_i),
    .cls_o  (cls_item)
  );

  // Hold the input only while both queue entries are taken
  assign in_stall_o = q_full;

  // ---- queue between front and back ---------------------------------------
  rppl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (cls_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  // ---- back end: advance link state and produce the result ----------------
  rppl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

// ===== design/rppl_front.sv =====
// ----------------------------------------------------------------------------
// rppl_front
// Classifies an incoming item: command, frame presence and frame validity.
// ----------------------------------------------------------------------------
`default_nettype none

module rppl_front import rppl_pkg::*; (
  input  var cfg_t      cfg_i,
  input  var in_item_t  item_i,
  output cls_item_t     cls_o
);

  logic common_ok;

  // Head, colour range and check byte are shared by both frame types
  assign common_ok = (item_i.rx_head == FRAME_HEAD)
                  && (item_i.rx_color >= cfg_i.color_first)
                  && (item_i.rx_color <= cfg_i.color_last)
                  && ((item_i.rx_head ^ item_i.rx_type ^ item_i.rx_sequence
                       ^ item_i.rx_color) == item_i.rx_check);

  always_comb begin
    cls_o.poll     = (item_i.command == CMD_POLL);
    cls_o.arrived  = item_i.frame_arrived;
    cls_o.req_ok   = common_ok && (item_i.rx_type == TYPE_REQUEST);
    cls_o.rep_ok   = common_ok && (item_i.rx_type == TYPE_REPLY);
    cls_o.seq_num  = item_i.rx_sequence;
    cls_o.color    = item_i.rx_color;
  end

endmodule

`default_nettype wire

// ===== design/rppl_queue.sv =====
// ----------------------------------------------------------------------------
// rppl_queue
// Two-entry queue of classified items between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rppl_queue import rppl_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      push_i,
  input  var cls_item_t push_item_i,
  output logic          full_o,
  output logic          valid_o,
  output cls_item_t     item_o,
  input  var logic      pop_i
);

  cls_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/rppl_back.sv =====
// ----------------------------------------------------------------------------
// rppl_back
// Carries out classified items: link state, LED timer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rppl_back import rppl_pkg::*; (
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var cfg_t      cfg_i,
  input  var logic      q_valid_i,
  input  var cls_item_t q_item_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  output out_item_t     out_item_o,
  input  var logic      out_stall_i
);

  phase_e     phase_q, phase_d;
  logic [7:0] seq_q, seq_d;
  logic [7:0] color_q, color_d;
  logic [7:0] wait_q, wait_d;
  logic [7:0] led_left_q, led_left_d;
  logic       led_on_q, led_on_d;
  logic [7:0] led_color_q, led_color_d;
  logic       out_valid_q;
  out_item_t  out_item_q, out_item_d;

  logic       send;
  logic [7:0] send_type;
  logic [7:0] send_seq;
  logic [7:0] send_color;

  // Take an item whenever the result register is free or being emptied
  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d     = phase_q;
    seq_d       = seq_q;
    color_d     = color_q;
    wait_d      = wait_q;
    led_left_d  = led_left_q;
    led_on_d    = led_on_q;
    led_color_d = led_color_q;
    send        = 1'b0;
    send_type   = TYPE_REQUEST;
    send_seq    = seq_q;
    send_color  = color_q;

    if (!q_item_i.poll) begin
      if (wait_q != 8'd0) begin
        wait_d = wait_q - 8'd1;
      end
      if (led_left_q != 8'd0) begin
        led_left_d = led_left_q - 8'd1;
        if (led_left_q == 8'd1) begin
          led_on_d    = 1'b0;
          led_color_d = 8'd0;
        end
      end
    end else if (cfg_i.role_master) begin
      unique case (phase_q)
        PH_SEND: begin
          send    = 1'b1;
          wait_d  = cfg_i.reply_ticks;
          phase_d = PH_WAIT;
        end
        PH_WAIT: begin
          if (q_item_i.arrived) begin
            if (q_item_i.rep_ok && (q_item_i.seq_num == seq_q)
                && (q_item_i.color == color_q)) begin
              wait_d  = cfg_i.next_ticks;
              phase_d = PH_PAUSE;
            end
          end else if (wait_q == 8'd0) begin
            phase_d = PH_SEND;
          end
        end
        PH_PAUSE: begin
          if (wait_q == 8'd0) begin
            seq_d   = seq_q + 8'd1;
            color_d = (color_q >= cfg_i.color_last) ? cfg_i.color_first
                                                    : color_q + 8'd1;
            phase_d = PH_SEND;
          end
        end
        default: begin
          phase_d = PH_SEND;
        end
      endcase
    end else begin
      if (q_item_i.arrived && q_item_i.req_ok) begin
        seq_d      = q_item_i.seq_num;
        color_d    = q_item_i.color;
        send       = 1'b1;
        send_type  = TYPE_REPLY;
        send_seq   = q_item_i.seq_num;
        send_color = q_item_i.color;
      end
    end

    if (send) begin
      led_color_d = send_color;
      led_on_d    = 1'b1;
      led_left_d  = cfg_i.led_ticks;
    end

    out_item_d.send_frame  = send;
    out_item_d.tx_head     = send ? FRAME_HEAD : 8'd0;
    out_item_d.tx_type     = send ? send_type : 8'd0;
    out_item_d.tx_sequence = send ? send_seq : 8'd0;
    out_item_d.tx_color    = send ? send_color : 8'd0;
    out_item_d.tx_check    = send ? (FRAME_HEAD ^ send_type ^ send_seq ^ send_color)
                                  : 8'd0;
    out_item_d.led_lit     = led_on_d;
    out_item_d.led_shade   = led_color_d;
    out_item_d.keep_awake  = send;
    unique case (phase_d)
      PH_SEND:  out_item_d.phase_now = PHASE_CODE_SEND;
      PH_WAIT:  out_item_d.phase_now = PHASE_CODE_WAIT;
      PH_PAUSE: out_item_d.phase_now = PHASE_CODE_PAUSE;
      default:  out_item_d.phase_now = PHASE_CODE_PAUSE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEND;
      seq_q       <= 8'd0;
      color_q     <= COLOR_FIRST_RST;
      wait_q      <= 8'd0;
      led_left_q  <= 8'd0;
      led_on_q    <= 1'b0;
      led_color_q <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q     <= phase_d;
        seq_q       <= seq_d;
        color_q     <= color_d;
        wait_q      <= wait_d;
        led_left_q  <= led_left_d;
        led_on_q    <= led_on_d;
        led_color_q <= led_color_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
